// ----- design/sbst_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sbst_pkg
// shared field widths, reset values and controller/datapath interface types
// ----------------------------------------------------------------------------
package sbst_pkg;

	localparam int ID_W   = 16;
	localparam int KEY_W  = 4;
	localparam int KEEP_W = 7;
	localparam int REC_W  = ID_W + KEY_W;

	localparam logic [KEEP_W-1:0] KEEP_RESET = 7'd64;

	// commands from controller to datapath
	typedef struct packed {
		logic load;          // accept input item into the store
		logic pass_prep;     // read entry 0, pointer to 1, clear moved
		logic pass_head;     // first entry into carry, read next
		logic pass_step;     // compare carry with next entry, write back smaller side
		logic pass_tail;     // write carry to last entry, pointer to 0
		logic emit_read;     // read entry at pointer
		logic emit_capture;  // load output register, advance pointer
		logic run_done;      // clear count and overflow after the set
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic more;      // pointer below stored count
		logic moved;     // a swap happened in this pass
		logic out_last;  // held result is the final one of the run
	} sts_t;

endpackage
`default_nettype wire

// ----- design/sbst_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sbst_dp
// record store, sort carry, counters, keep register and output register
// ----------------------------------------------------------------------------
module sbst_dp #(
	parameter int MAX_RECORDS = 64
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire  sbst_pkg::cmd_t              cmd,
	output sbst_pkg::sts_t                    sts,
	input  wire  [sbst_pkg::ID_W-1:0]         record_id,
	input  wire  [sbst_pkg::KEY_W-1:0]        error_count,
	input  wire                               cfg_we,
	input  wire  [sbst_pkg::KEEP_W-1:0]       keep_count,
	output logic [sbst_pkg::ID_W-1:0]         sorted_id,
	output logic [sbst_pkg::KEY_W-1:0]        sorted_errors,
	output logic                              last_out,
	output logic                              overflowed
);

	localparam int ADDR_W = $clog2(MAX_RECORDS);
	localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
	localparam int KW     = sbst_pkg::KEEP_W;
	localparam int RW     = sbst_pkg::REC_W;
	localparam int KEYW   = sbst_pkg::KEY_W;

	logic [RW-1:0] mem [MAX_RECORDS];

	logic [RW-1:0]    rd_q;
	logic [RW-1:0]    carry_q;
	logic [CNT_W-1:0] loaded_q;
	logic [CNT_W-1:0] idx_q;
	logic             ovf_q;
	logic             moved_q;
	logic [KW-1:0]    keep_q;

	logic              we;
	logic [ADDR_W-1:0] wa;
	logic [RW-1:0]     wd;
	logic              re;
	logic [ADDR_W-1:0] ra;
	logic              swap;
	logic              full;
	logic [CNT_W-1:0]  idx_m2;
	logic [CNT_W-1:0]  last_idx;
	logic [KW-1:0]     keep_eff;
	logic [KW-1:0]     loaded_ext;
	logic [KW-1:0]     emit_n;
	logic [KW-1:0]     idx_p1;

	assign full       = (loaded_q == CNT_W'(MAX_RECORDS));
	assign swap       = carry_q[KEYW-1:0] > rd_q[KEYW-1:0];
	assign idx_m2     = idx_q - CNT_W'(2);
	assign last_idx   = loaded_q - CNT_W'(1);
	assign keep_eff   = (keep_q == '0) ? KW'(1) : keep_q;
	assign loaded_ext = KW'(loaded_q);
	assign emit_n     = (keep_eff > loaded_ext) ? loaded_ext : keep_eff;
	assign idx_p1     = KW'(idx_q) + KW'(1);

	assign sts.more  = idx_q < loaded_q;
	assign sts.moved = moved_q;
	assign sts.out_last = last_out;

	// memory port selection
	always_comb begin
		we = 1'b0;
		wa = '0;
		wd = carry_q;
		re = 1'b0;
		ra = idx_q[ADDR_W-1:0];
		if (cmd.load) begin
			we = !full;
			wa = loaded_q[ADDR_W-1:0];
			wd = {record_id, error_count};
		end else if (cmd.pass_step) begin
			we = 1'b1;
			wa = idx_m2[ADDR_W-1:0];
			wd = swap ? rd_q : carry_q;
		end else if (cmd.pass_tail) begin
			we = 1'b1;
			wa = last_idx[ADDR_W-1:0];
		end
		if (cmd.pass_prep) begin
			re = 1'b1;
			ra = '0;
		end else if (cmd.pass_head || cmd.pass_step) begin
			re = sts.more;
		end else if (cmd.emit_read) begin
			re = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd_q <= mem[ra];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pass_head) begin
			carry_q <= rd_q;
		end else if (cmd.pass_step && !swap) begin
			carry_q <= rd_q;
		end
		if (cmd.emit_capture) begin
			sorted_id     <= rd_q[RW-1:KEYW];
			sorted_errors <= rd_q[KEYW-1:0];
			overflowed    <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= '0;
			ovf_q    <= 1'b0;
			idx_q    <= '0;
			moved_q  <= 1'b0;
			keep_q   <= sbst_pkg::KEEP_RESET;
			last_out <= 1'b0;
		end else begin
			if (cfg_we) begin
				keep_q <= keep_count;
			end
			if (cmd.load) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					loaded_q <= loaded_q + CNT_W'(1);
				end
			end
			if (cmd.run_done) begin
				loaded_q <= '0;
				ovf_q    <= 1'b0;
			end
			if (cmd.pass_prep) begin
				idx_q   <= CNT_W'(1);
				moved_q <= 1'b0;
			end
			if ((cmd.pass_head || cmd.pass_step) && sts.more) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (cmd.pass_step && swap) begin
				moved_q <= 1'b1;
			end
			if (cmd.pass_tail) begin
				idx_q <= '0;
			end
			if (cmd.emit_capture) begin
				last_out <= (idx_p1 == emit_n);
				idx_q    <= idx_q + CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ----- design/sbst_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sbst_ctrl
// sequencer for load, bubble passes and emit
// ----------------------------------------------------------------------------
module sbst_ctrl (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             in_valid,
	input  wire             in_last,
	output logic            in_ready,
	output logic            out_valid,
	input  wire             out_ready,
	input  wire  sbst_pkg::sts_t  sts,
	output sbst_pkg::cmd_t  cmd
);

	localparam logic [2:0] S_LOAD  = 3'd0;
	localparam logic [2:0] S_PREP  = 3'd1;
	localparam logic [2:0] S_HEAD  = 3'd2;
	localparam logic [2:0] S_RUN   = 3'd3;
	localparam logic [2:0] S_TAIL  = 3'd4;
	localparam logic [2:0] S_ERD   = 3'd5;
	localparam logic [2:0] S_EWAIT = 3'd6;
	localparam logic [2:0] S_EOUT  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready  = (state_q == S_LOAD);
	assign out_valid = (state_q == S_EOUT);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_LOAD: begin
				cmd.load = in_valid;
				if (in_valid && in_last) begin
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				cmd.pass_prep = 1'b1;
				state_d       = S_HEAD;
			end
			S_HEAD: begin
				cmd.pass_head = 1'b1;
				state_d       = sts.more ? S_RUN : S_TAIL;
			end
			S_RUN: begin
				cmd.pass_step = 1'b1;
				state_d       = sts.more ? S_RUN : S_TAIL;
			end
			S_TAIL: begin
				cmd.pass_tail = 1'b1;
				state_d       = sts.moved ? S_PREP : S_ERD;
			end
			S_ERD: begin
				cmd.emit_read = 1'b1;
				state_d       = S_EWAIT;
			end
			S_EWAIT: begin
				cmd.emit_capture = 1'b1;
				state_d          = S_EOUT;
			end
			S_EOUT: begin
				if (out_ready) begin
					if (sts.out_last) begin
						cmd.run_done = 1'b1;
						state_d      = S_LOAD;
					end else begin
						cmd.emit_read = 1'b1;
						state_d       = S_EWAIT;
					end
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output sides open together");

	a_last_in_starts_sort: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_last) |=> (!in_ready && !out_valid))
		else $error("sort did not start after final record");

	a_last_out_reopens: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && sts.out_last) |=> in_ready)
		else $error("loading not reopened after final result");

	a_moved_clear_after_prep: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pass_prep |=> !sts.moved)
		else $error("moved flag not cleared at pass start");
`endif

endmodule
`default_nettype wire

// ----- design/stable_bubble_sort_truncate.sv -----
// loading: one item per cycle; after the final record the sort runs up to n
//   passes over the record store with one read and one write port (n stored)
// emit: each result is read from the store, captured and held until out_ready,
//   and the next one is read only then; one set at a time
// reset: arst_n clears control, counts and overflow, and sets keep_count to 64;
//   the record store is not cleared, only entries of the current set are read
`default_nettype none
// ----------------------------------------------------------------------------
// stable_bubble_sort_truncate
// loads a set of records, stable-sorts them by error count with adjacent-swap
// passes and emits the best keep_count records (at least one, at most all stored)
// ----------------------------------------------------------------------------
module stable_bubble_sort_truncate #(
	parameter int MAX_RECORDS = 64
) (
	input  wire                              clk,
	input  wire                              arst_n,
	// input item channel
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire  [sbst_pkg::ID_W-1:0]        record_id,
	input  wire  [sbst_pkg::KEY_W-1:0]       error_count,
	input  wire                              last_record,
	// result item channel
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [sbst_pkg::ID_W-1:0]        sorted_id,
	output logic [sbst_pkg::KEY_W-1:0]       sorted_errors,
	output logic                             last_out,
	output logic                             overflowed,
	// keep_count register write
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [sbst_pkg::KEEP_W-1:0]      keep_count
);

	sbst_pkg::cmd_t cmd;
	sbst_pkg::sts_t sts;

	// the register write is always taken
	assign cfg_ready = 1'b1;

	// sequencer: load state, bubble pass states, emit states
	sbst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_last   (last_record),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// store plus carry register: each pass streams the store once, the carry
	// holds the largest key seen so far and equal keys never swap, which keeps
	// arrival order among records with the same error count
	sbst_dp #(
		.MAX_RECORDS (MAX_RECORDS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.record_id     (record_id),
		.error_count   (error_count),
		.cfg_we        (cfg_valid),
		.keep_count    (keep_count),
		.sorted_id     (sorted_id),
		.sorted_errors (sorted_errors),
		.last_out      (last_out),
		.overflowed    (overflowed)
	);

endmodule
`default_nettype wire
